// ----- rtl/hoir_pkg.sv -----
// types, constants and codes shared by the heap object index resolver
package hoir_pkg;

  localparam int ADDR_W        = 48;
  localparam int HEADER_BYTES  = 24;
  localparam int ENTRY_COUNT_W = 11;
  localparam int ALIGN_BITS    = 3;
  localparam int DESC_MIN_BITS = 16;
  localparam int CFG_INDEX_W   = 2;

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_HEADER = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_TOP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_END    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ATOMIC_DESC = 2'd3;

  typedef enum logic [2:0] {
    STAT_STARTED   = 3'd0,
    STAT_RECORDED  = 3'd1,
    STAT_WALK_DONE = 3'd2,
    STAT_BAD       = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_HIT       = 3'd5,
    STAT_MISS      = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_H_TOP,
    ST_H_TOTAL,
    ST_H_END,
    ST_H_WRAP,
    ST_H_LIMIT,
    ST_H_PAST,
    ST_H_DLO,
    ST_H_DHI,
    ST_H_PSTART,
    ST_H_DONE,
    ST_L_BOUND,
    ST_L_LOW,
    ST_L_HIGH,
    ST_S_READ,
    ST_S_CMP,
    ST_L_SUM,
    ST_L_BEND,
    ST_L_FINAL
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] payload_size;
    logic [ADDR_W-1:0] descriptor_address;
    logic [ADDR_W-1:0] lookup_address;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic [ADDR_W-1:0]        address;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic              sub;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic              carry;
    logic [ADDR_W-1:0] sum;
  } alu_res_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pstart;
    logic [ADDR_W-1:0] extent;
  } entry_t;

endpackage

// ----- rtl/hoir_addsub.sv -----
// shared adder/subtractor with carry out, used for the address sums and ordered compares
module hoir_addsub (
  input  hoir_pkg::alu_op_t  op,
  output hoir_pkg::alu_res_t res
);
  import hoir_pkg::*;

  logic [ADDR_W-1:0] b_in;
  logic [ADDR_W:0]   total;

  // subtract: a + ~b + 1, carry set when a >= b
  assign b_in  = op.sub ? ~op.b : op.b;
  assign total = {1'b0, op.a} + {1'b0, b_in} + {{ADDR_W{1'b0}}, op.sub};
  assign res.carry = total[ADDR_W];
  assign res.sum   = total[ADDR_W-1:0];

endmodule

// ----- rtl/heap_object_index_resolver.sv -----
// top level: header walk, object table and address lookup over one shared adder
//
// Usage: write heap_base, heap_top, heap_end and atomic_descriptor through the
// cfg_we/cfg_index/cfg_data port while the block is idle. An item is accepted
// on a clock edge with start high and busy low; busy then stays high until the
// result is produced. Each item of func 0..2 yields one result on result with
// result_valid high for exactly one cycle; func 3 yields nothing. The receiver
// cannot stall, so nothing waits on the output side.
// Order of steps: a start build runs ST_START; a header item checks the walk in
// ST_H_TOP and, unless the walk is over, goes on from ST_H_TOTAL to ST_H_DONE;
// a lookup runs ST_L_BOUND, ST_L_LOW and ST_L_HIGH, stops there on an early
// miss, else takes k binary search steps of ST_S_READ and ST_S_CMP (k up to 11
// with 1024 entries) and, if a start lies at or below the address, ends with
// ST_L_SUM, ST_L_BEND and ST_L_FINAL. One item is in flight at a time; the
// single 49-bit adder does the address sums and ordered compares in turn.
// Reset clears the walk (no walk active), the entry count and configuration
// (atomic_descriptor reads 1). Table contents are not cleared: only entries
// below the entry count are ever read.
module heap_object_index_resolver #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  hoir_pkg::item_t                      item,
  output logic                                 result_valid,
  output hoir_pkg::result_t                    result,
  input  logic                                 cfg_we,
  input  logic [hoir_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hoir_pkg::ADDR_W-1:0]          cfg_data
);
  import hoir_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] HB = ADDR_W'(HEADER_BYTES);

  state_t state, state_next;

  logic [ADDR_W-1:0] heap_base, heap_top, heap_end, atomic_desc;
  item_t             item_q;
  logic [ADDR_W-1:0] walk_addr;
  logic              walk_stopped;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] total, end_addr, acc;
  logic              bound_c, f_wrap, f_lim, f_past, f_dlo, f_dhi, f_miss;
  logic [CNT_W-1:0]  lo, hi, mid;
  logic              found;
  logic [ADDR_W-1:0] found_start, found_ext;

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_q;
  logic              mem_we;

  alu_op_t           alu_op;
  alu_res_t          alu_res;

  logic              emit;
  status_t           emit_status;
  logic [ADDR_W-1:0] emit_addr;

  logic              dplaus, hdr_ok, table_full, hdr_record;
  logic              size_zero;

  hoir_addsub u_addsub (
    .op  (alu_op),
    .res (alu_res)
  );

  assign busy = (state != ST_IDLE);
  assign mid  = lo + ((hi - lo) >> 1);

  assign size_zero  = (item_q.payload_size == '0);
  assign dplaus     = (item_q.descriptor_address == '0)
                   || (item_q.descriptor_address == atomic_desc)
                   || ((item_q.descriptor_address[ALIGN_BITS-1:0] == '0)
                       && (|item_q.descriptor_address[ADDR_W-1:DESC_MIN_BITS])
                       && !(f_dlo && f_dhi));
  assign hdr_ok     = (size_zero && dplaus)
                   || (!size_zero && (item_q.payload_size[ALIGN_BITS-1:0] == '0)
                       && f_wrap && f_lim);
  assign table_full = (count == CNT_W'(TABLE_DEPTH));
  assign hdr_record = (state == ST_H_DONE) && hdr_ok && !table_full;
  assign mem_we     = hdr_record;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    emit        = 1'b0;
    emit_status = STAT_STARTED;
    emit_addr   = '0;
    alu_op      = '0;
    count_next  = count;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (item.func)
            FUNC_START:  state_next = ST_START;
            FUNC_HEADER: state_next = ST_H_TOP;
            FUNC_LOOKUP: state_next = ST_L_BOUND;
            default:     state_next = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        alu_op      = '{sub: 1'b1, a: heap_base, b: heap_top};
        count_next  = '0;
        emit        = 1'b1;
        emit_status = STAT_STARTED;
        emit_addr   = heap_base;
        state_next  = ST_IDLE;
      end
      ST_H_TOP: begin
        alu_op = '{sub: 1'b1, a: walk_addr, b: heap_top};
        if (walk_stopped || alu_res.carry) begin
          emit        = 1'b1;
          emit_status = STAT_WALK_DONE;
          emit_addr   = walk_addr;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_H_TOTAL;
        end
      end
      ST_H_TOTAL: begin
        alu_op     = '{sub: 1'b0, a: HB, b: item_q.payload_size};
        state_next = ST_H_END;
      end
      ST_H_END: begin
        alu_op     = '{sub: 1'b0, a: walk_addr, b: total};
        state_next = ST_H_WRAP;
      end
      ST_H_WRAP: begin
        alu_op     = '{sub: 1'b1, a: walk_addr, b: end_addr};
        state_next = ST_H_LIMIT;
      end
      ST_H_LIMIT: begin
        alu_op     = '{sub: 1'b1, a: heap_top, b: end_addr};
        state_next = ST_H_PAST;
      end
      ST_H_PAST: begin
        alu_op     = '{sub: 1'b1, a: end_addr, b: heap_top};
        state_next = ST_H_DLO;
      end
      ST_H_DLO: begin
        alu_op     = '{sub: 1'b1, a: item_q.descriptor_address, b: heap_base};
        state_next = ST_H_DHI;
      end
      ST_H_DHI: begin
        alu_op     = '{sub: 1'b1, a: item_q.descriptor_address, b: heap_end};
        state_next = ST_H_PSTART;
      end
      ST_H_PSTART: begin
        alu_op     = '{sub: 1'b0, a: walk_addr, b: HB};
        state_next = ST_H_DONE;
      end
      ST_H_DONE: begin
        emit       = 1'b1;
        state_next = ST_IDLE;
        if (!hdr_ok) begin
          emit_status = STAT_BAD;
          emit_addr   = walk_addr;
        end else if (table_full) begin
          emit_status = STAT_FULL;
          emit_addr   = walk_addr;
        end else begin
          count_next  = count + 1'b1;
          emit_status = STAT_RECORDED;
          emit_addr   = end_addr;
        end
      end
      ST_L_BOUND: begin
        alu_op     = '{sub: 1'b0, a: heap_base, b: HB};
        state_next = ST_L_LOW;
      end
      ST_L_LOW: begin
        alu_op     = '{sub: 1'b1, a: item_q.lookup_address, b: acc};
        state_next = ST_L_HIGH;
      end
      ST_L_HIGH: begin
        alu_op = '{sub: 1'b1, a: heap_top, b: item_q.lookup_address};
        if (f_miss || !alu_res.carry || (count == '0)) begin
          emit        = 1'b1;
          emit_status = STAT_MISS;
          state_next  = ST_IDLE;
        end else begin
          state_next = ST_S_READ;
        end
      end
      ST_S_READ: begin
        if (lo < hi) begin
          state_next = ST_S_CMP;
        end else if (found) begin
          state_next = ST_L_SUM;
        end else begin
          emit        = 1'b1;
          emit_status = STAT_MISS;
          state_next  = ST_IDLE;
        end
      end
      ST_S_CMP: begin
        alu_op     = '{sub: 1'b1, a: item_q.lookup_address, b: rd_q.pstart};
        state_next = ST_S_READ;
      end
      ST_L_SUM: begin
        alu_op     = '{sub: 1'b0, a: found_start, b: found_ext};
        state_next = ST_L_BEND;
      end
      ST_L_BEND: begin
        alu_op     = '{sub: 1'b1, a: acc, b: HB};
        state_next = ST_L_FINAL;
      end
      ST_L_FINAL: begin
        alu_op     = '{sub: 1'b1, a: acc, b: item_q.lookup_address};
        emit       = 1'b1;
        state_next = ST_IDLE;
        if (alu_res.carry) begin
          emit_status = STAT_HIT;
          emit_addr   = found_start;
        end else begin
          emit_status = STAT_MISS;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[IDX_W-1:0]] <= '{pstart: acc, extent: total};
    end
    rd_q <= mem[mid[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base    <= '0;
      heap_top     <= '0;
      heap_end     <= '0;
      atomic_desc  <= ADDR_W'(1);
      walk_addr    <= '0;
      walk_stopped <= 1'b1;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE:   heap_base   <= cfg_data;
          CFG_HEAP_TOP:    heap_top    <= cfg_data;
          CFG_HEAP_END:    heap_end    <= cfg_data;
          CFG_ATOMIC_DESC: atomic_desc <= cfg_data;
          default:         heap_base   <= heap_base;
        endcase
      end
      count        <= count_next;
      result_valid <= emit;
      case (state)
        ST_START: begin
          walk_addr    <= heap_base;
          walk_stopped <= alu_res.carry;
        end
        ST_H_TOP: begin
          if (walk_stopped || alu_res.carry) begin
            walk_stopped <= 1'b1;
          end
        end
        ST_H_DONE: begin
          if (hdr_record) begin
            walk_addr    <= end_addr;
            walk_stopped <= f_past;
          end else begin
            walk_stopped <= 1'b1;
          end
        end
        default: begin
          walk_stopped <= walk_stopped;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    result <= '{status: emit_status, address: emit_addr,
                entry_count: ENTRY_COUNT_W'(count_next)};
    if (state == ST_IDLE && start) begin
      item_q <= item;
    end
    case (state)
      ST_H_TOTAL:  total    <= alu_res.sum;
      ST_H_END:    end_addr <= alu_res.sum;
      ST_H_WRAP:   f_wrap   <= !alu_res.carry;
      ST_H_LIMIT:  f_lim    <= alu_res.carry;
      ST_H_PAST:   f_past   <= alu_res.carry;
      ST_H_DLO:    f_dlo    <= alu_res.carry;
      ST_H_DHI:    f_dhi    <= !alu_res.carry;
      ST_H_PSTART: acc      <= alu_res.sum;
      ST_L_BOUND: begin
        acc     <= alu_res.sum;
        bound_c <= alu_res.carry;
      end
      ST_L_LOW: begin
        f_miss <= bound_c || !alu_res.carry;
      end
      ST_L_HIGH: begin
        lo    <= '0;
        hi    <= count;
        found <= 1'b0;
      end
      ST_S_CMP: begin
        if (alu_res.carry) begin
          found       <= 1'b1;
          found_start <= rd_q.pstart;
          found_ext   <= rd_q.extent;
          lo          <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      ST_L_SUM:  acc <= alu_res.sum;
      ST_L_BEND: acc <= alu_res.sum;
      default: begin
        acc <= acc;
      end
    endcase
  end

  // a result leaves only at the end of a busy item
  assert property (@(posedge clk) disable iff (rst) result_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  assert property (@(posedge clk) disable iff (rst) result_valid |-> !busy)
    else $error("block still busy after its result");

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  assert property (@(posedge clk) disable iff (rst) (state == ST_S_CMP) |-> (lo < hi))
    else $error("search compare with an empty interval");

endmodule

// ----- sim/heap_object_index_resolver_tb.sv -----
// self-checking testbench for heap_object_index_resolver: directed and random walks and lookups
module heap_object_index_resolver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hoir_pkg::*;

  localparam int          DEPTH        = 1024;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [47:0] ADDR_MAX     = '1;
  localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  item_t                  item = '0;
  logic                   result_valid;
  result_t                result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_HEAP_BASE;
  logic [ADDR_W-1:0]      cfg_data = '0;

  heap_object_index_resolver dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [47:0] cfg_base = '0;
  logic [47:0] cfg_top = '0;
  logic [47:0] cfg_end = '0;
  logic [47:0] cfg_atomic = 48'd1;
  logic [47:0] tbl_pstart [DEPTH];
  logic [47:0] tbl_extent [DEPTH];
  int unsigned rec_count = 0;
  logic [47:0] walk_addr = '0;
  bit          walk_done = 1'b1;

  result_t     expected_results [$];
  result_t     want;
  bit          failed = 1'b0;
  int unsigned idle_pct = 0;

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic item_t mk_item(input logic [1:0] f, input logic [47:0] size, desc, addr);
    item_t it;
    it.func = f;
    it.payload_size = size;
    it.descriptor_address = desc;
    it.lookup_address = addr;
    return it;
  endfunction

  function automatic bit desc_plausible(input logic [47:0] d);
    if (d == '0 || d == cfg_atomic) return 1'b1;
    if (d[2:0] != 3'd0) return 1'b0;
    if (d < 48'h10000) return 1'b0;
    if (d >= cfg_base && d < cfg_end) return 1'b0;
    return 1'b1;
  endfunction

  function automatic result_t mk_result(input status_t s, input logic [47:0] a);
    result_t r;
    r.status = s;
    r.address = a;
    r.entry_count = 11'(rec_count);
    return r;
  endfunction

  function automatic bit predict_resolution(input item_t it, output result_t r);
    logic [47:0] scan, total, fin, p, bend;
    bit          filler, ok, found;
    int unsigned lo, hi, mid, idx;
    case (it.func)
      FUNC_START: begin
        rec_count = 0;
        walk_addr = cfg_base;
        walk_done = (cfg_base >= cfg_top);
        r = mk_result(STAT_STARTED, walk_addr);
        return 1'b1;
      end
      FUNC_HEADER: begin
        scan = walk_addr;
        if (walk_done || scan >= cfg_top) begin
          walk_done = 1'b1;
          r = mk_result(STAT_WALK_DONE, scan);
          return 1'b1;
        end
        total = 48'(HEADER_BYTES) + it.payload_size;
        fin = scan + total;
        filler = (it.payload_size == '0) && desc_plausible(it.descriptor_address);
        ok = filler || (it.payload_size != '0 && it.payload_size[2:0] == 3'd0 &&
                        fin > scan && fin <= cfg_top);
        if (!ok) begin
          walk_done = 1'b1;
          r = mk_result(STAT_BAD, scan);
          return 1'b1;
        end
        if (rec_count >= DEPTH) begin
          walk_done = 1'b1;
          r = mk_result(STAT_FULL, scan);
          return 1'b1;
        end
        tbl_pstart[rec_count] = scan + 48'(HEADER_BYTES);
        tbl_extent[rec_count] = total;
        rec_count++;
        walk_addr = fin;
        if (fin >= cfg_top) walk_done = 1'b1;
        r = mk_result(STAT_RECORDED, fin);
        return 1'b1;
      end
      FUNC_LOOKUP: begin
        p = it.lookup_address;
        if ({1'b0, p} < {1'b0, cfg_base} + 49'(HEADER_BYTES) || p > cfg_top || rec_count == 0) begin
          r = mk_result(STAT_MISS, '0);
          return 1'b1;
        end
        lo = 0;
        hi = rec_count;
        idx = 0;
        found = 1'b0;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tbl_pstart[mid] <= p) begin
            idx = mid;
            found = 1'b1;
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        bend = tbl_pstart[idx] - 48'(HEADER_BYTES) + tbl_extent[idx];
        if (found && p >= tbl_pstart[idx] && p <= bend) r = mk_result(STAT_HIT, tbl_pstart[idx]);
        else r = mk_result(STAT_MISS, '0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: status %0d address %h count %0d",
                 $time, result.status, result.address, result.entry_count);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          failed = 1'b1;
        end
        if (result.address !== want.address) begin
          $display("%0t: address expected %h actual %h", $time, want.address, result.address);
          failed = 1'b1;
        end
        if (result.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, want.entry_count, result.entry_count);
          failed = 1'b1;
        end
      end
    end
  end

  task automatic send_item(input item_t it);
    result_t r;
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_resolution(it, r)) expected_results.push_back(r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_heap(input logic [47:0] base, top, hend, atomic);
    logic [47:0]            vals [4];
    logic [CFG_INDEX_W-1:0] idx [4];
    vals = '{base, top, hend, atomic};
    idx = '{CFG_HEAP_BASE, CFG_HEAP_TOP, CFG_HEAP_END, CFG_ATOMIC_DESC};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_base = base;
    cfg_top = top;
    cfg_end = hend;
    cfg_atomic = atomic;
  endtask

  function automatic item_t gen_header(input bit valid_only);
    logic [47:0] size, desc, room;
    int unsigned pick;
    room = cfg_top - walk_addr;
    desc = rand48();
    pick = valid_only ? $urandom_range(0, 69) : $urandom_range(0, 99);
    if (pick < 70) begin
      size = 48'(8 * $urandom_range(1, 48));
    end else if (pick < 75) begin
      size = (room > 48'd32) ? ((room - 48'd24) & ~48'h7) : 48'd8;
    end else if (pick < 85) begin
      size = '0;
      case ($urandom_range(0, 2))
        0: desc = '0;
        1: desc = cfg_atomic;
        default: desc = (rand48() & ~48'h7) | 48'h10000;
      endcase
    end else if (pick < 90) begin
      size = 48'(8 * $urandom_range(0, 40) + $urandom_range(1, 7));
    end else if (pick < 94) begin
      size = (room & ~48'h7) + 48'd8;
    end else if (pick < 97) begin
      size = rand48() & ~48'h7;
    end else begin
      size = '0;
      desc = (cfg_base + 48'(8 * $urandom_range(0, 64))) | 48'($urandom_range(0, 1));
    end
    return mk_item(FUNC_HEADER, size, desc, rand48());
  endfunction

  function automatic item_t gen_lookup();
    logic [47:0] p;
    int unsigned k, reach, pick;
    pick = $urandom_range(0, 9);
    if (pick < 7 && rec_count != 0) begin
      k = $urandom_range(0, rec_count - 1);
      if (pick == 6) begin
        p = tbl_pstart[k] - 48'(HEADER_BYTES) + tbl_extent[k] + 48'($urandom_range(0, 1));
      end else begin
        reach = (tbl_extent[k] > 48'd4000) ? 4016 : int'(tbl_extent[k]) + 16;
        p = tbl_pstart[k] - 48'd32 + 48'($urandom_range(0, reach));
      end
    end else if (pick == 7) begin
      p = cfg_base + 48'($urandom_range(0, 30));
    end else if (pick == 8) begin
      p = cfg_top + 48'($urandom_range(0, 2)) - 48'd1;
    end else begin
      p = rand48();
    end
    return mk_item(FUNC_LOOKUP, rand48(), rand48(), p);
  endfunction

  task automatic test_after_reset();
    send_item(mk_item(FUNC_HEADER, 48'd8, '0, '0));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, 48'd100));
    send_item(mk_item(FUNC_UNUSED, ADDR_MAX, ADDR_MAX, ADDR_MAX));
    send_item(mk_item(FUNC_START, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, 48'd8, '0, '0));
  endtask

  task automatic test_directed();
    logic [47:0] b, t;
    b = 48'h100000;
    t = 48'h100200;
    set_heap(b, t, 48'h180000, ADDR_MAX);
    send_item(mk_item(FUNC_LOOKUP, '0, '0, b + 48'd30));
    send_item(mk_item(FUNC_START, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, 48'd8, rand48(), '0));
    send_item(mk_item(FUNC_HEADER, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, '0, ADDR_MAX, '0));
    send_item(mk_item(FUNC_HEADER, '0, 48'h200000, '0));
    send_item(mk_item(FUNC_HEADER, 48'd16, '0, '0));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, b + 48'd23));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, b + 48'd24));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, b + 48'd32));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, t + 48'd1));
    send_item(mk_item(FUNC_HEADER, '0, 48'h100008, '0));
    send_item(mk_item(FUNC_HEADER, 48'd8, '0, '0));
    send_item(mk_item(FUNC_START, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, t - b - 48'd24, '0, '0));
    send_item(mk_item(FUNC_HEADER, 48'd8, '0, '0));
    send_item(mk_item(FUNC_START, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, 48'd12, '0, '0));
    // filler whose end wraps past the top of the address space
    set_heap(ADDR_MAX - 48'd15, ADDR_MAX, ADDR_MAX, '0);
    send_item(mk_item(FUNC_START, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, '0, '0, '0));
    send_item(mk_item(FUNC_HEADER, 48'd8, '0, '0));
    send_item(mk_item(FUNC_LOOKUP, '0, '0, ADDR_MAX));
  endtask

  task automatic test_table_full();
    logic [47:0] b;
    b = (rand48() >> 2) & ~48'h7;
    idle_pct = 11;
    set_heap(b, b + 48'd430000, b + 48'd500000, rand48());
    send_item(mk_item(FUNC_START, rand48(), rand48(), rand48()));
    repeat (DEPTH) send_item(gen_header(1'b1));
    send_item(mk_item(FUNC_HEADER, 48'd8, rand48(), rand48()));
    send_item(mk_item(FUNC_HEADER, 48'd8, rand48(), rand48()));
    repeat (40) send_item(gen_lookup());
    drain();
    repeat (40) send_item(gen_lookup());
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned n_items);
    logic [47:0] base, top, hend, atomic;
    logic [1:0]  f;
    int unsigned sent, pick;
    item_t       it;
    sent = 0;
    idle_pct = pct;
    while (sent < n_items) begin
      case ($urandom_range(0, 7))
        5: begin
          base = '0;
          top = 48'($urandom_range(0, 400));
        end
        6: begin
          top = ADDR_MAX - 48'($urandom_range(0, 8));
          base = top - 48'($urandom_range(64, 3000));
        end
        7: begin
          base = rand48();
          top = base >> 1;
        end
        default: begin
          base = rand48() >> 1;
          if ($urandom_range(0, 1) != 0) base[2:0] = 3'd0;
          top = base + 48'($urandom_range(64, 6000));
        end
      endcase
      case ($urandom_range(0, 3))
        0: hend = top + 48'($urandom_range(0, 4096));
        1: hend = ADDR_MAX;
        2: hend = rand48();
        default: hend = base;
      endcase
      case ($urandom_range(0, 3))
        0: atomic = 48'd1;
        1: atomic = rand48();
        2: atomic = rand48() & ~48'h7;
        default: atomic = '0;
      endcase
      set_heap(base, top, hend, atomic);
      send_item(mk_item(FUNC_START, rand48(), rand48(), rand48()));
      sent++;
      repeat ($urandom_range(30, 80)) begin
        pick = $urandom_range(0, 99);
        if ((walk_done && pick < 20) || (pick >= 84 && pick < 88)) begin
          it = mk_item(FUNC_START, rand48(), rand48(), rand48());
        end else if (pick < 50) begin
          it = gen_header(1'b0);
        end else if (pick < 84) begin
          it = gen_lookup();
        end else begin
          case ($urandom_range(0, 2))
            0: f = FUNC_HEADER;
            1: f = FUNC_LOOKUP;
            default: f = FUNC_UNUSED;
          endcase
          it = mk_item(f, rand48(), rand48(), rand48());
        end
        send_item(it);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_after_reset();
    test_directed();
    test_table_full();
    test_random_traffic(11, 250);
    test_random_traffic(64, 250);
    test_random_traffic(0, 250);
    drain();
    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- heap_object_index_resolver.f -----
rtl/hoir_pkg.sv
rtl/hoir_addsub.sv
rtl/heap_object_index_resolver.sv
sim/heap_object_index_resolver_tb.sv
